### rtl/cbbsf_pkg.sv
package cbbsf_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int EXTENT_WIDTH    = COORD_WIDTH - 1;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [EXTENT_WIDTH-1:0]       extent_t;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}});

    // 0.2 m, 0.2 m, 0.4 m and 0.5 m at 2^-16 m per unit.
    localparam extent_t MAX_EXTENT_X_RESET = extent_t'(13107);
    localparam extent_t MAX_EXTENT_Y_RESET = extent_t'(13107);
    localparam extent_t MAX_EXTENT_Z_RESET = extent_t'(26214);
    localparam coord_t  HEIGHT_LIMIT_RESET = coord_t'(32768);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MAX_EXTENT_X = 2'd0,
        CFG_MAX_EXTENT_Y = 2'd1,
        CFG_MAX_EXTENT_Z = 2'd2,
        CFG_HEIGHT_LIMIT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        coord_t low_x;
        coord_t high_x;
        coord_t low_y;
        coord_t high_y;
        coord_t low_z;
        coord_t high_z;
    } box_t;

endpackage

### rtl/cbbsf_point_if.sv
interface cbbsf_point_if;
    import cbbsf_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   end_of_cluster;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output end_of_cluster, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input end_of_cluster, output ready);
endinterface

### rtl/cbbsf_result_if.sv
interface cbbsf_result_if;
    import cbbsf_pkg::*;

    logic   valid;
    logic   ready;
    logic   accepted;
    coord_t centre_x;
    coord_t centre_y;
    coord_t centre_z;

    modport source (output valid, output accepted, output centre_x, output centre_y,
                    output centre_z, input ready);
    modport sink   (input valid, input accepted, input centre_x, input centre_y,
                    input centre_z, output ready);
endinterface

### rtl/cluster_bounding_box_size_filter.sv
// A result is registered after its cluster's last point has passed the input and finished-box registers.
// Throughput: one point per cycle unless stalled; the input register, the finished-box register and the
// result register decouple the two sides, so points keep flowing while a result waits.
// Only the last point of a cluster is stalled: both later registers full and result.ready low.
// Reset (rst_n low, asynchronous): pipeline empty, running extremes cleared, limits at
// 0.2 m / 0.2 m / 0.4 m extent and 0.5 m height.
module cluster_bounding_box_size_filter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    cbbsf_point_if.sink                           point,
    cbbsf_result_if.source                        result,
    input  logic                                  cfg_we,
    input  logic [cbbsf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [cbbsf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import cbbsf_pkg::*;

    // Configuration registers
    extent_t max_extent_x_reg;
    extent_t max_extent_y_reg;
    extent_t max_extent_z_reg;
    coord_t  height_limit_reg;

    // Input stage
    logic   a_valid_reg;
    coord_t a_x_reg;
    coord_t a_y_reg;
    coord_t a_z_reg;
    logic   a_last_reg;

    // Running extremes and the finished box of a closed cluster
    box_t run_reg;
    box_t run_upd;
    box_t run_next;
    logic b_valid_reg;
    box_t b_box_reg;

    // Result stage
    logic   out_valid_reg;
    logic   out_accepted_reg;
    coord_t out_cx_reg;
    coord_t out_cy_reg;
    coord_t out_cz_reg;

    logic c_ready;
    logic b_ready;
    logic a_fire;
    logic in_fire;
    logic close_fire;

    logic [COORD_WIDTH:0] ext_x;
    logic [COORD_WIDTH:0] ext_y;
    logic [COORD_WIDTH:0] ext_z;
    logic signed [COORD_WIDTH:0] sum_x;
    logic signed [COORD_WIDTH:0] sum_y;
    logic signed [COORD_WIDTH:0] sum_z;
    logic ok;

    assign c_ready    = !out_valid_reg || result.ready;
    assign b_ready    = !b_valid_reg || c_ready;
    assign a_fire     = a_valid_reg && (!a_last_reg || b_ready);
    assign close_fire = a_fire && a_last_reg;
    assign point.ready = !a_valid_reg || a_fire;
    assign in_fire    = point.valid && point.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_extent_x_reg <= MAX_EXTENT_X_RESET;
            max_extent_y_reg <= MAX_EXTENT_Y_RESET;
            max_extent_z_reg <= MAX_EXTENT_Z_RESET;
            height_limit_reg <= HEIGHT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MAX_EXTENT_X: max_extent_x_reg <= cfg_data[EXTENT_WIDTH-1:0];
                CFG_MAX_EXTENT_Y: max_extent_y_reg <= cfg_data[EXTENT_WIDTH-1:0];
                CFG_MAX_EXTENT_Z: max_extent_z_reg <= cfg_data[EXTENT_WIDTH-1:0];
                CFG_HEIGHT_LIMIT: height_limit_reg <= coord_t'(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (point.ready)
        begin
            a_valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_x_reg    <= point.pos_x;
            a_y_reg    <= point.pos_y;
            a_z_reg    <= point.pos_z;
            a_last_reg <= point.end_of_cluster;
        end
    end

    always_comb
    begin
        run_upd.low_x  = (a_x_reg < run_reg.low_x)  ? a_x_reg : run_reg.low_x;
        run_upd.high_x = (a_x_reg > run_reg.high_x) ? a_x_reg : run_reg.high_x;
        run_upd.low_y  = (a_y_reg < run_reg.low_y)  ? a_y_reg : run_reg.low_y;
        run_upd.high_y = (a_y_reg > run_reg.high_y) ? a_y_reg : run_reg.high_y;
        run_upd.low_z  = (a_z_reg < run_reg.low_z)  ? a_z_reg : run_reg.low_z;
        run_upd.high_z = (a_z_reg > run_reg.high_z) ? a_z_reg : run_reg.high_z;

        run_next = run_reg;
        if (a_fire)
        begin
            if (a_last_reg)
            begin
                run_next = '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN};
            end
            else
            begin
                run_next = run_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN};
            b_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            if (b_ready)
            begin
                b_valid_reg <= close_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_fire)
        begin
            b_box_reg <= run_upd;
        end
    end

    // Extents are nonnegative and one bit wider than a coordinate, so they never wrap.
    always_comb
    begin
        ext_x = {b_box_reg.high_x[COORD_WIDTH-1], b_box_reg.high_x}
              - {b_box_reg.low_x[COORD_WIDTH-1], b_box_reg.low_x};
        ext_y = {b_box_reg.high_y[COORD_WIDTH-1], b_box_reg.high_y}
              - {b_box_reg.low_y[COORD_WIDTH-1], b_box_reg.low_y};
        ext_z = {b_box_reg.high_z[COORD_WIDTH-1], b_box_reg.high_z}
              - {b_box_reg.low_z[COORD_WIDTH-1], b_box_reg.low_z};
        sum_x = {b_box_reg.high_x[COORD_WIDTH-1], b_box_reg.high_x}
              + {b_box_reg.low_x[COORD_WIDTH-1], b_box_reg.low_x};
        sum_y = {b_box_reg.high_y[COORD_WIDTH-1], b_box_reg.high_y}
              + {b_box_reg.low_y[COORD_WIDTH-1], b_box_reg.low_y};
        sum_z = {b_box_reg.high_z[COORD_WIDTH-1], b_box_reg.high_z}
              + {b_box_reg.low_z[COORD_WIDTH-1], b_box_reg.low_z};
        ok = (b_box_reg.low_z < height_limit_reg)
          && (ext_x < {2'b00, max_extent_x_reg})
          && (ext_y < {2'b00, max_extent_y_reg})
          && (ext_z < {2'b00, max_extent_z_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            out_accepted_reg <= ok;
            out_cx_reg       <= ok ? coord_t'(sum_x[COORD_WIDTH:1]) : '0;
            out_cy_reg       <= ok ? coord_t'(sum_y[COORD_WIDTH:1]) : '0;
            out_cz_reg       <= ok ? coord_t'(sum_z[COORD_WIDTH:1]) : '0;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.accepted = out_accepted_reg;
    assign result.centre_x = out_cx_reg;
    assign result.centre_y = out_cy_reg;
    assign result.centre_z = out_cz_reg;

endmodule

### rtl/cbbsf_checker.sv
module cbbsf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_accepted,
    input logic [cbbsf_pkg::COORD_WIDTH-1:0] out_cx,
    input logic [cbbsf_pkg::COORD_WIDTH-1:0] out_cy,
    input logic [cbbsf_pkg::COORD_WIDTH-1:0] out_cz
);
    import cbbsf_pkg::*;

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_accepted)
            && $stable(out_cx) && $stable(out_cy) && $stable(out_cz))
        else $error("stalled result changed");

    // A rejected cluster reports a zero centre.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_accepted |-> out_cx == '0 && out_cy == '0 && out_cz == '0)
        else $error("rejected cluster with nonzero centre");

    // Input back-pressure only comes from a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // Points stay refused only while the output stays stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && $past(!in_ready) |-> $past(out_valid && !out_ready))
        else $error("input stalled while output drained");

endmodule

bind cluster_bounding_box_size_filter cbbsf_checker u_cbbsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (point.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_accepted (result.accepted),
    .out_cx       (result.centre_x),
    .out_cy       (result.centre_y),
    .out_cz       (result.centre_z)
);
